[src/pad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pad_pkg;

    // Coordinate and configuration register widths; the payload structs are sized from these.
    localparam int PAD_COORD_W       = 24;
    localparam int PAD_CFG_W         = 16;
    localparam int PAD_COS_FRAC_BITS = 14;
    // Multiplier digit: bits of the second operand retired per cycle.
    localparam int PAD_DIGIT_W       = 8;
    localparam int PAD_QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic signed [PAD_COORD_W-1:0] px;
        logic signed [PAD_COORD_W-1:0] py;
        logic signed [PAD_COORD_W-1:0] pz;
        logic                          final_point;
    } point_t;

    typedef struct packed {
        logic signed [PAD_COORD_W-1:0] kept_x;
        logic signed [PAD_COORD_W-1:0] kept_y;
        logic signed [PAD_COORD_W-1:0] kept_z;
        logic                          run_end;
        logic                          line_end;
    } kept_t;

    // Classified work passed from the front end to the back end.
    typedef struct packed {
        point_t pt;
        logic   decide;      // held point needs the turn test
        logic   emit_p;      // this point is a result (first or last of the line)
        logic   set_anchor;  // this point becomes the anchor
        logic   set_held;    // this point becomes the held point
    } cmd_t;

endpackage

`default_nettype wire

[src/polyline_angle_decimator.sv]
// A first or closing point with no turn test gives its result without using the multiplier.
// A point that needs the turn test keeps the back end busy for nine small and up to four
// wide products through one shared 8-bit-digit multiplier.
// The back end handles one point at a time; a two-entry queue lets the input run ahead.
// Reset (rst_n, asynchronous) ends any line in progress and sets cos_threshold to 1.0.
`timescale 1ns / 1ps
`default_nettype none

module polyline_angle_decimator
#(
    parameter int COS_FRAC_BITS = pad_pkg::PAD_COS_FRAC_BITS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pad_pkg::PAD_CFG_W-1:0] cfg_data,
    input  wire logic                          point_valid,
    output logic                               point_stall,
    input  wire pad_pkg::point_t               point,
    output logic                               kept_valid,
    input  wire logic                          kept_stall,
    output pad_pkg::kept_t                     kept
);
    import pad_pkg::*;

    logic [PAD_CFG_W-1:0] cos_reg;
    logic                 cmd_valid, cmd_pop;
    cmd_t                 cmd;

    // Threshold register, 1.0 after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= PAD_CFG_W'(64'd1 << COS_FRAC_BITS);
        end
        else if (cfg_we)
        begin
            cos_reg <= cfg_data;
        end
    end

    pad_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    pad_back #(.COS_FRAC_BITS(COS_FRAC_BITS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .cos_threshold (cos_reg),
        .kept_valid    (kept_valid),
        .kept_stall    (kept_stall),
        .kept          (kept)
    );

endmodule

`default_nettype wire

[src/pad_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pad_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          point_valid,
    output logic               point_stall,
    input  wire pad_pkg::point_t point,
    output logic               cmd_valid,
    output pad_pkg::cmd_t      cmd,
    input  wire logic          cmd_pop
);
    import pad_pkg::*;

    localparam int PTR_W = $clog2(PAD_QUEUE_DEPTH);

    logic               started_reg, started_next;
    logic               held_valid_reg, held_valid_next;
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    cmd_t               queue_reg [PAD_QUEUE_DEPTH];
    cmd_t               new_cmd;
    logic               push;

    assign point_stall = (count_reg == (PTR_W+1)'(PAD_QUEUE_DEPTH));
    assign push        = point_valid && !point_stall;
    assign cmd_valid   = (count_reg != '0);
    assign cmd         = queue_reg[rd_ptr_reg];

    // Classify the point from the line position alone.
    always_comb
    begin
        new_cmd.pt = point;
        if (!started_reg)
        begin
            new_cmd.decide     = 1'b0;
            new_cmd.emit_p     = 1'b1;
            new_cmd.set_anchor = !point.final_point;
            new_cmd.set_held   = 1'b0;
            held_valid_next    = 1'b0;
        end
        else
        begin
            new_cmd.decide     = held_valid_reg;
            new_cmd.emit_p     = point.final_point;
            new_cmd.set_anchor = 1'b0;
            new_cmd.set_held   = !point.final_point;
            held_valid_next    = !point.final_point;
        end
        started_next = !point.final_point;
    end

    // Line position flags and queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            held_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (push)
            begin
                started_reg    <= started_next;
                held_valid_reg <= held_valid_next;
                wr_ptr_reg     <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !cmd_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && cmd_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

[src/pad_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module pad_mul
#(
    parameter int OPW = 64
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [OPW-1:0]   a,
    input  wire logic [OPW-1:0]   b,
    output logic                  done,
    output logic [2*OPW-1:0]      product
);
    import pad_pkg::*;

    localparam int PW = 2 * OPW;

    logic            busy_reg;
    logic [PW-1:0]   a_reg;
    logic [OPW-1:0]  b_reg;
    logic [PW-1:0]   acc_reg;
    logic [PW-1:0]   partial;

    // One digit of b times the shifted a.
    assign partial = a_reg * PW'(b_reg[PAD_DIGIT_W-1:0]);
    assign done    = busy_reg && (b_reg == '0);
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Shift and add, finishing as soon as no digits of b remain.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= PW'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg && !done)
        begin
            acc_reg <= acc_reg + partial;
            a_reg   <= a_reg << PAD_DIGIT_W;
            b_reg   <= b_reg >> PAD_DIGIT_W;
        end
    end

endmodule

`default_nettype wire

[src/pad_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module pad_back
#(
    parameter int COS_FRAC_BITS = pad_pkg::PAD_COS_FRAC_BITS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire pad_pkg::cmd_t                 cmd,
    output logic                               cmd_pop,
    input  wire logic [pad_pkg::PAD_CFG_W-1:0] cos_threshold,
    output logic                               kept_valid,
    input  wire logic                          kept_stall,
    output pad_pkg::kept_t                     kept
);
    import pad_pkg::*;

    localparam int W    = PAD_COORD_W;
    localparam int MAGW = W + 1;
    localparam int SQW  = 2 * MAGW;
    localparam int SUMW = SQW + 2;
    localparam int LHSW = SUMW + COS_FRAC_BITS;
    localparam int NNW  = 2 * SUMW;
    localparam int OPW  = (LHSW > NNW) ? LHSW : NNW;
    localparam int PW   = 2 * OPW;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_SMALL_GO, S_SMALL_WAIT, S_CMP,
        S_BIG_GO, S_BIG_WAIT, S_EMIT_H, S_EMIT_P
    } state_t;

    state_t                 state_reg;
    logic signed [W-1:0]    anchor_reg [3];
    logic signed [W-1:0]    held_reg [3];
    logic [MAGW-1:0]        m1_reg [3];
    logic [MAGW-1:0]        m2_reg [3];
    logic                   s1_reg [3];
    logic                   s2_reg [3];
    logic                   z1_reg, z2_reg;
    logic [SUMW-1:0]        n1_reg, n2_reg, pos_reg, neg_reg;
    logic [LHSW-1:0]        lhs_reg;
    logic                   dneg_reg;
    logic [PAD_CFG_W-1:0]   cm_reg;
    logic [PW-1:0]          l2_reg, t_reg, nn_reg;
    logic                   exc_reg;
    logic [1:0]             kind_reg, ax_reg, big_reg;
    logic                   kept_valid_reg;
    kept_t                  kept_reg;

    logic signed [W-1:0]    pt [3];
    logic signed [MAGW-1:0] d1 [3];
    logic signed [MAGW-1:0] d2 [3];
    logic                   out_free;
    logic                   out_load;
    logic                   mul_start, mul_done;
    logic [OPW-1:0]         mul_a, mul_b;
    logic [PW-1:0]          mul_p;
    logic                   cneg;
    logic [PAD_CFG_W-1:0]   cmag;
    logic                   dneg;
    logic [SUMW-1:0]        ddiff;

    assign pt[0] = cmd.pt.px;
    assign pt[1] = cmd.pt.py;
    assign pt[2] = cmd.pt.pz;

    // Vector components from anchor to held and from held to the new point.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d1[k] = MAGW'(held_reg[k]) - MAGW'(anchor_reg[k]);
            d2[k] = MAGW'(pt[k]) - MAGW'(held_reg[k]);
        end
    end

    assign cneg  = cos_threshold[PAD_CFG_W-1];
    assign cmag  = cneg ? (~cos_threshold + 1'b1) : cos_threshold;
    assign dneg  = (neg_reg > pos_reg);
    assign ddiff = dneg ? (neg_reg - pos_reg) : (pos_reg - neg_reg);

    assign out_free   = !kept_valid_reg || !kept_stall;
    assign kept_valid = kept_valid_reg;
    assign kept       = kept_reg;
    assign mul_start  = (state_reg == S_SMALL_GO) || (state_reg == S_BIG_GO);
    assign cmd_pop    = (state_reg == S_EMIT_P) && (!cmd.emit_p || out_free);

    // A result is loaded when the held point is kept or the current point is emitted.
    assign out_load = ((state_reg == S_EMIT_H) && exc_reg && out_free) ||
                      (cmd_pop && cmd.emit_p);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SMALL_GO)
        begin
            unique case (kind_reg)
                2'd0:
                begin
                    mul_a = OPW'(m1_reg[ax_reg]);
                    mul_b = OPW'(m1_reg[ax_reg]);
                end
                2'd1:
                begin
                    mul_a = OPW'(m2_reg[ax_reg]);
                    mul_b = OPW'(m2_reg[ax_reg]);
                end
                default:
                begin
                    mul_a = OPW'(m1_reg[ax_reg]);
                    mul_b = OPW'(m2_reg[ax_reg]);
                end
            endcase
        end
        else
        begin
            unique case (big_reg)
                2'd0:
                begin
                    mul_a = OPW'(lhs_reg);
                    mul_b = OPW'(lhs_reg);
                end
                2'd1:
                begin
                    mul_a = OPW'(cm_reg);
                    mul_b = OPW'(cm_reg);
                end
                2'd2:
                begin
                    mul_a = OPW'(n1_reg);
                    mul_b = OPW'(n2_reg);
                end
                default:
                begin
                    mul_a = OPW'(t_reg);
                    mul_b = OPW'(nn_reg);
                end
            endcase
        end
    end

    pad_mul #(.OPW(OPW)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // Sequencer: turn test when the command asks for it, then up to two results, then state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kept_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                kept_valid_reg <= 1'b1;
            end
            else if (!kept_stall)
            begin
                kept_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    exc_reg <= 1'b0;
                    if (cmd_valid)
                    begin
                        state_reg <= cmd.decide ? S_PREP : S_EMIT_H;
                    end
                end
                S_PREP:
                begin
                    z1_reg <= (d1[0] == '0) && (d1[1] == '0) && (d1[2] == '0);
                    z2_reg <= (d2[0] == '0) && (d2[1] == '0) && (d2[2] == '0);
                    for (int k = 0; k < 3; k++)
                    begin
                        m1_reg[k] <= d1[k][MAGW-1] ? MAGW'(-d1[k]) : MAGW'(d1[k]);
                        m2_reg[k] <= d2[k][MAGW-1] ? MAGW'(-d2[k]) : MAGW'(d2[k]);
                        s1_reg[k] <= d1[k][MAGW-1];
                        s2_reg[k] <= d2[k][MAGW-1];
                    end
                    n1_reg    <= '0;
                    n2_reg    <= '0;
                    pos_reg   <= '0;
                    neg_reg   <= '0;
                    kind_reg  <= 2'd0;
                    ax_reg    <= 2'd0;
                    state_reg <= S_SMALL_GO;
                end
                S_SMALL_GO:
                begin
                    state_reg <= S_SMALL_WAIT;
                end
                S_SMALL_WAIT:
                begin
                    if (mul_done)
                    begin
                        unique case (kind_reg)
                            2'd0: n1_reg <= n1_reg + SUMW'(mul_p);
                            2'd1: n2_reg <= n2_reg + SUMW'(mul_p);
                            default:
                            begin
                                if (s1_reg[ax_reg] != s2_reg[ax_reg])
                                begin
                                    neg_reg <= neg_reg + SUMW'(mul_p);
                                end
                                else
                                begin
                                    pos_reg <= pos_reg + SUMW'(mul_p);
                                end
                            end
                        endcase
                        if (ax_reg == 2'd2)
                        begin
                            ax_reg <= 2'd0;
                            if (kind_reg == 2'd2)
                            begin
                                state_reg <= S_CMP;
                            end
                            else
                            begin
                                kind_reg  <= kind_reg + 2'd1;
                                state_reg <= S_SMALL_GO;
                            end
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_SMALL_GO;
                        end
                    end
                end
                S_CMP:
                begin
                    dneg_reg <= dneg;
                    lhs_reg  <= LHSW'(ddiff) << COS_FRAC_BITS;
                    cm_reg   <= cmag;
                    big_reg  <= 2'd0;
                    // Zero vectors and sign mismatches settle the test at once.
                    priority if (z1_reg || z2_reg)
                    begin
                        exc_reg   <= 1'b0;
                        state_reg <= S_EMIT_H;
                    end
                    else if (dneg && !cneg)
                    begin
                        exc_reg   <= 1'b1;
                        state_reg <= S_EMIT_H;
                    end
                    else if (!dneg && (cneg || (cos_threshold == '0)))
                    begin
                        exc_reg   <= 1'b0;
                        state_reg <= S_EMIT_H;
                    end
                    else
                    begin
                        state_reg <= S_BIG_GO;
                    end
                end
                S_BIG_GO:
                begin
                    state_reg <= S_BIG_WAIT;
                end
                S_BIG_WAIT:
                begin
                    if (mul_done)
                    begin
                        unique case (big_reg)
                            2'd0: l2_reg <= mul_p;
                            2'd1: t_reg  <= mul_p;
                            2'd2: nn_reg <= mul_p;
                            default:
                            begin
                                exc_reg <= dneg_reg ? (l2_reg > mul_p) : (l2_reg < mul_p);
                            end
                        endcase
                        big_reg   <= big_reg + 2'd1;
                        state_reg <= (big_reg == 2'd3) ? S_EMIT_H : S_BIG_GO;
                    end
                end
                S_EMIT_H:
                begin
                    if (!exc_reg)
                    begin
                        state_reg <= S_EMIT_P;
                    end
                    else if (out_free)
                    begin
                        kept_reg.kept_x  <= held_reg[0];
                        kept_reg.kept_y  <= held_reg[1];
                        kept_reg.kept_z  <= held_reg[2];
                        kept_reg.run_end <= !cmd.emit_p;
                        kept_reg.line_end <= 1'b0;
                        for (int k = 0; k < 3; k++)
                        begin
                            anchor_reg[k] <= held_reg[k];
                        end
                        state_reg <= S_EMIT_P;
                    end
                end
                S_EMIT_P:
                begin
                    if (cmd_pop)
                    begin
                        if (cmd.emit_p)
                        begin
                            kept_reg.kept_x   <= pt[0];
                            kept_reg.kept_y   <= pt[1];
                            kept_reg.kept_z   <= pt[2];
                            kept_reg.run_end  <= 1'b1;
                            kept_reg.line_end <= cmd.pt.final_point;
                        end
                        for (int k = 0; k < 3; k++)
                        begin
                            if (cmd.set_anchor)
                            begin
                                anchor_reg[k] <= pt[k];
                            end
                            if (cmd.set_held)
                            begin
                                held_reg[k] <= pt[k];
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_SMALL_WAIT) || (state_reg == S_BIG_WAIT))
        else $error("multiplier finished while the sequencer was not waiting");

    a_keep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_H) && exc_reg |-> !z1_reg && !z2_reg)
        else $error("held point kept with a zero vector");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        kept_valid_reg && kept_stall |=> kept_valid_reg && $stable(kept_reg))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
